@@ hdl/cfb_pkg.sv @@
// Shared types and constants for the command frame builder.
package cfb_pkg;

  localparam int unsigned MAX_FRAME_DEFAULT = 256;
  localparam int unsigned HEADER_OVERHEAD   = 9;
  localparam int unsigned QUEUE_DEPTH       = 4;

  localparam logic [7:0] SYNC_R     = 8'h52;
  localparam logic [7:0] SYNC_F     = 8'h46;
  localparam logic [7:0] FRAME_TYPE = 8'h00;

  localparam logic       OP_BEGIN   = 1'b0;
  localparam logic       OP_PAYLOAD = 1'b1;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_TOO_LONG = 2'd1;
  localparam logic [1:0] STATUS_NO_FRAME = 2'd2;

  // Index of the last header byte; an empty frame's checksum takes the step after it.
  localparam logic [3:0] STEP_HDR_LAST = 4'd7;

  typedef enum logic [2:0] {
    CMD_HDR,
    CMD_HDR_CLOSE,
    CMD_PAY,
    CMD_PAY_CLOSE,
    CMD_ERR_LONG,
    CMD_ERR_STRAY
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  code;
    logic [15:0] length;
    logic [7:0]  data;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_req_t;

endpackage

@@ hdl/cfb_if.sv @@
// Request channel interfaces for the command frame builder.
interface cfb_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [7:0]  frame_code;
  logic [15:0] payload_length;
  logic [7:0]  payload_byte;

  modport source (output valid, op, frame_code, payload_length, payload_byte, input ready);
  modport sink   (input valid, op, frame_code, payload_length, payload_byte, output ready);
endinterface

interface cfb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       frame_end;
  logic [1:0] status;

  modport source (output valid, out_byte, last_of_run, frame_end, status, input ready);
  modport sink   (input valid, out_byte, last_of_run, frame_end, status, output ready);
endinterface

@@ hdl/cfb_front.sv @@
// Front end: accepts requests, tracks the open frame and classifies each request.
module cfb_front #(
  parameter int unsigned MAX_FRAME = cfb_pkg::MAX_FRAME_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  cfb_in_if.sink            cmd,
  input  logic              queue_full,
  output cfb_pkg::cmd_req_t push
);

  localparam int unsigned LEN_LIMIT = MAX_FRAME - cfb_pkg::HEADER_OVERHEAD;

  logic        frame_open;
  logic        frame_open_next;
  logic [15:0] bytes_remaining;
  logic [15:0] bytes_remaining_next;
  logic [15:0] remaining_dec;
  logic        accept;

  assign cmd.ready     = !queue_full;
  assign accept        = cmd.valid && !queue_full;
  assign remaining_dec = bytes_remaining - 16'd1;

  always_comb begin
    push.valid           = accept;
    push.cmd.code        = cmd.frame_code;
    push.cmd.length      = cmd.payload_length;
    push.cmd.data        = cmd.payload_byte;
    push.cmd.kind        = cfb_pkg::CMD_ERR_STRAY;
    frame_open_next      = frame_open;
    bytes_remaining_next = bytes_remaining;
    if (cmd.op == cfb_pkg::OP_BEGIN) begin
      frame_open_next      = 1'b0;
      bytes_remaining_next = 16'd0;
      if (cmd.payload_length > 16'(LEN_LIMIT)) begin
        push.cmd.kind = cfb_pkg::CMD_ERR_LONG;
      end else if (cmd.payload_length == 16'd0) begin
        push.cmd.kind = cfb_pkg::CMD_HDR_CLOSE;
      end else begin
        push.cmd.kind        = cfb_pkg::CMD_HDR;
        frame_open_next      = 1'b1;
        bytes_remaining_next = cmd.payload_length;
      end
    end else if (frame_open) begin
      if (remaining_dec == 16'd0) begin
        push.cmd.kind        = cfb_pkg::CMD_PAY_CLOSE;
        frame_open_next      = 1'b0;
        bytes_remaining_next = 16'd0;
      end else begin
        push.cmd.kind        = cfb_pkg::CMD_PAY;
        bytes_remaining_next = remaining_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open      <= 1'b0;
      bytes_remaining <= 16'd0;
    end else if (accept) begin
      frame_open      <= frame_open_next;
      bytes_remaining <= bytes_remaining_next;
    end
  end

  a_open_has_count: assert property (@(posedge clk) disable iff (rst)
    frame_open |-> bytes_remaining != 16'd0)
    else $error("open frame with no bytes remaining");

  a_close_clears: assert property (@(posedge clk) disable iff (rst)
    accept && push.cmd.kind == cfb_pkg::CMD_PAY_CLOSE |=> !frame_open)
    else $error("frame still open after its closing byte");

endmodule

@@ hdl/cfb_queue.sv @@
// Short command queue between the front end and the frame emitter.
module cfb_queue (
  input  logic              clk,
  input  logic              rst,
  input  cfb_pkg::cmd_req_t push,
  input  logic              pop,
  output logic              full,
  output logic              empty,
  output cfb_pkg::cmd_t     head
);

  localparam int unsigned DEPTH = cfb_pkg::QUEUE_DEPTH;
  localparam int unsigned PW    = $clog2(DEPTH);

  cfb_pkg::cmd_t  entries [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [PW:0]    count;
  logic           do_push;
  logic           do_pop;

  assign full    = count == (PW+1)'(DEPTH);
  assign empty   = count == '0;
  assign do_push = push.valid && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (PW+1)'(DEPTH))
    else $error("queue count beyond depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    full |-> !push.valid)
    else $error("request pushed into a full queue");

endmodule

@@ hdl/cfb_back.sv @@
// Back end: expands queued commands into frame bytes and keeps the checksum.
module cfb_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_wr_en,
  input  logic [15:0]   cfg_wr_data,
  input  cfb_pkg::cmd_t head,
  input  logic          empty,
  output logic          pop,
  cfb_out_if.source     frame
);

  logic [15:0] node_addr;
  logic [3:0]  step;
  logic [7:0]  running_sum;
  logic [7:0]  running_sum_next;
  logic [7:0]  sum_base;
  logic [7:0]  hdr_byte;
  logic [7:0]  byte_sel;
  logic        last_sel;
  logic        end_sel;
  logic [1:0]  status_sel;
  logic        done;
  logic        emit;
  logic        is_hdr;

  assign emit = !empty && (!frame.valid || frame.ready);
  assign pop  = emit && done;

  assign is_hdr   = head.kind == cfb_pkg::CMD_HDR || head.kind == cfb_pkg::CMD_HDR_CLOSE;
  assign sum_base = (is_hdr && step == 4'd0) ? 8'd0 : running_sum;

  always_comb begin
    case (step)
      4'd0:    hdr_byte = cfb_pkg::SYNC_R;
      4'd1:    hdr_byte = cfb_pkg::SYNC_F;
      4'd2:    hdr_byte = cfb_pkg::FRAME_TYPE;
      4'd3:    hdr_byte = node_addr[15:8];
      4'd4:    hdr_byte = node_addr[7:0];
      4'd5:    hdr_byte = head.code;
      4'd6:    hdr_byte = head.length[15:8];
      4'd7:    hdr_byte = head.length[7:0];
      default: hdr_byte = 8'd0;
    endcase
  end

  always_comb begin
    // Checksum closes the frame unless an arm below says otherwise.
    byte_sel         = 8'd0 - running_sum;
    last_sel         = 1'b1;
    end_sel          = 1'b1;
    status_sel       = cfb_pkg::STATUS_OK;
    done             = 1'b1;
    running_sum_next = 8'd0;
    case (head.kind)
      cfb_pkg::CMD_HDR, cfb_pkg::CMD_HDR_CLOSE: begin
        if (step <= cfb_pkg::STEP_HDR_LAST) begin
          byte_sel         = hdr_byte;
          end_sel          = 1'b0;
          last_sel         = head.kind == cfb_pkg::CMD_HDR && step == cfb_pkg::STEP_HDR_LAST;
          done             = last_sel;
          running_sum_next = sum_base + hdr_byte;
        end
      end
      cfb_pkg::CMD_PAY, cfb_pkg::CMD_PAY_CLOSE: begin
        if (step == 4'd0) begin
          byte_sel         = head.data;
          end_sel          = 1'b0;
          last_sel         = head.kind == cfb_pkg::CMD_PAY;
          done             = last_sel;
          running_sum_next = running_sum + head.data;
        end
      end
      cfb_pkg::CMD_ERR_LONG: begin
        byte_sel   = 8'd0;
        end_sel    = 1'b0;
        status_sel = cfb_pkg::STATUS_TOO_LONG;
      end
      cfb_pkg::CMD_ERR_STRAY: begin
        byte_sel         = 8'd0;
        end_sel          = 1'b0;
        status_sel       = cfb_pkg::STATUS_NO_FRAME;
        running_sum_next = running_sum;
      end
      default: begin
        byte_sel         = 8'd0;
        running_sum_next = running_sum;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_addr <= 16'd0;
    end else if (cfg_wr_en) begin
      node_addr <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step        <= 4'd0;
      running_sum <= 8'd0;
      frame.valid <= 1'b0;
    end else begin
      if (emit) begin
        step        <= done ? 4'd0 : step + 4'd1;
        running_sum <= running_sum_next;
        frame.valid <= 1'b1;
      end else if (frame.ready) begin
        frame.valid <= 1'b0;
      end
    end
  end

  // Payload of the output register; hold while stalled.
  always_ff @(posedge clk) begin
    if (emit) begin
      frame.out_byte    <= byte_sel;
      frame.last_of_run <= last_sel;
      frame.frame_end   <= end_sel;
      frame.status      <= status_sel;
    end
  end

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    frame.valid && frame.frame_end |-> frame.last_of_run && frame.status == cfb_pkg::STATUS_OK)
    else $error("checksum not marked as last ok byte");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    frame.valid && frame.status != cfb_pkg::STATUS_OK |-> frame.out_byte == 8'd0
      && frame.last_of_run)
    else $error("error result with payload");

endmodule

@@ hdl/command_frame_builder.sv @@
// Top level of the command frame builder.
// The input accepts a request whenever the four-entry command queue has room; the emitter
// drains the queue at one frame byte per cycle while the sink is ready: a begin request
// yields the eight header bytes (then the checksum when the length is zero), a payload byte
// itself (then the checksum when it closes the frame), an error one zero byte. The output
// register sets the sustained rate: one result per cycle while the sink is ready. The user
// must write the device address (cfg_wr_en/cfg_wr_data) only while idle; it is unenforced.
module command_frame_builder #(
  parameter int unsigned MAX_FRAME = cfb_pkg::MAX_FRAME_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  cfb_in_if.sink      cmd,
  cfb_out_if.source   frame
);

  cfb_pkg::cmd_req_t push;
  cfb_pkg::cmd_t     head;
  logic              queue_full;
  logic              queue_empty;
  logic              pop;

  cfb_front #(
    .MAX_FRAME (MAX_FRAME)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .queue_full (queue_full),
    .push       (push)
  );

  cfb_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (pop),
    .full  (queue_full),
    .empty (queue_empty),
    .head  (head)
  );

  cfb_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .head        (head),
    .empty       (queue_empty),
    .pop         (pop),
    .frame       (frame)
  );

endmodule
